// ===== design/udclz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udclz_pkg
// Shared constant for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
package udclz_pkg;

  // Width of the dividend, divisor and quotient fields on the channels
  localparam int unsigned FIELD_W = 32;

endpackage

// ===== design/udclz_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udclz_if
// Valid/ready channels for operand items and quotient items.
// ----------------------------------------------------------------------------
interface udclz_in_if;
  import udclz_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udclz_out_if;
  import udclz_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

// ===== design/udclz_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udclz_stage
// One restoring division step with its pipeline register.
// ----------------------------------------------------------------------------
module udclz_stage #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] num_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  logic [DATA_WIDTH-1:0] den_in,
  output logic                  vld_out,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] num_out,
  output logic [DATA_WIDTH-1:0] quo_out,
  output logic [DATA_WIDTH-1:0] den_out
);

  logic                  vld_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_in, num_in[DATA_WIDTH-1]};
    take    = (shifted >= {1'b0, den_in});
    diff    = shifted - {1'b0, den_in};
    rem_nxt = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    num_nxt = {num_in[DATA_WIDTH-2:0], 1'b0};
    quo_nxt = {quo_in[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      den_r <= den_in;
    end
  end

  assign vld_out = vld_r;
  assign rem_out = rem_r;
  assign num_out = num_r;
  assign quo_out = quo_r;
  assign den_out = den_r;

endmodule

// ===== design/unsigned_divider_clz.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_divider_clz
// Fully pipelined unsigned integer divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a dividend and a divisor; out_ch carries the quotient,
//   floor(dividend / divisor), or zero when the divisor is zero.
//   Operands are taken at DATA_WIDTH bits: narrower settings drop the upper
//   field bits, wider ones zero-extend them; the quotient is resized to 32 bits.
//   An accepted item passes through the stage chain to out_ch.valid: one
//   restoring step (a DATA_WIDTH+1 bit compare and subtract) per stage.
//   Throughput is one item per cycle while out_ch is not stalled.
//   When out_ch is stalled with a result waiting, every stage holds and
//   in_ch.ready drops; nothing is lost or repeated. Bubbles in the chain
//   keep moving while the output register is empty or being drained.
//   Reset (rst_n low, synchronous) clears every stage valid bit; data
//   registers are not reset.
// ----------------------------------------------------------------------------
module unsigned_divider_clz #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  udclz_in_if.sink      in_ch,
  udclz_out_if.source   out_ch
);
  import udclz_pkg::*;

  logic                  en;
  logic                  vld_a [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_a [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] num_a [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quo_a [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_a [0:DATA_WIDTH];

  // Advance the whole chain unless a finished item is held at the output
  assign en          = !vld_a[DATA_WIDTH] || out_ch.ready;
  assign in_ch.ready = en;

  assign vld_a[0] = in_ch.valid;
  assign rem_a[0] = '0;
  assign quo_a[0] = '0;
  assign num_a[0] = DATA_WIDTH'(in_ch.dividend);
  assign den_a[0] = DATA_WIDTH'(in_ch.divisor);

  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
    udclz_stage #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld_a[g]),
      .rem_in  (rem_a[g]),
      .num_in  (num_a[g]),
      .quo_in  (quo_a[g]),
      .den_in  (den_a[g]),
      .vld_out (vld_a[g+1]),
      .rem_out (rem_a[g+1]),
      .num_out (num_a[g+1]),
      .quo_out (quo_a[g+1]),
      .den_out (den_a[g+1])
    );
  end

  // Drop the all-ones pattern a zero divisor leaves behind
  assign out_ch.valid    = vld_a[DATA_WIDTH];
  assign out_ch.quotient = (den_a[DATA_WIDTH] == '0) ? '0
                                                      : FIELD_W'(quo_a[DATA_WIDTH]);

endmodule

// ===== design/udclz_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udclz_checker
// Port-level checks for the pipelined divider, bound to the top level.
// ----------------------------------------------------------------------------
module udclz_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [udclz_pkg::FIELD_W-1:0] quotient
);
  import udclz_pkg::*;

  // Reset empties the pipeline
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input is refused only while a result is held at the output
  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input refused with output free");

  a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // A stalled result stays and holds its value
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(quotient)))
    else $error("stalled result changed");

endmodule

bind unsigned_divider_clz udclz_checker u_udclz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .quotient  (out_ch.quotient)
);

// ===== tb/tb_unsigned_divider_clz.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsigned_divider_clz
// Self-checking bench for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
// A queue of operand pairs, directed corner cases first and then random
// pairs drawn from several operand shapes, feeds a clocked driver on in_ch.
// Every accepted pair is turned into an expected quotient by a bit-serial
// restoring division. A clocked monitor on out_ch compares each quotient
// with the oldest expected one. Both sides idle in short random bursts,
// except near the end of the run.
// ----------------------------------------------------------------------------
module tb_unsigned_divider_clz;
  import udclz_pkg::*;

  localparam int unsigned DW          = 32;
  localparam int unsigned RAND_ITEMS  = 2000;
  localparam int unsigned TAIL_ITEMS  = 200;
  localparam int unsigned DRAIN_WAIT  = DW + 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [63:0] OPER_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DW);
  localparam logic [FIELD_W-1:0] ALL_ONES = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT  = 32'h8000_0000;

  typedef enum int unsigned {
    SHAPE_FULL,
    SHAPE_NARROW_DIVISOR,
    SHAPE_ZERO_DIVISOR,
    SHAPE_DIVISOR_ABOVE,
    SHAPE_EXACT_MULTIPLE,
    SHAPE_EDGE_VALUES,
    SHAPE_COUNT
  } operand_shape_e;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } operands_t;

  logic clk;
  logic rst_n;

  udclz_in_if  in_if ();
  udclz_out_if out_if ();

  unsigned_divider_clz #(
    .DATA_WIDTH (DW)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  operands_t          operand_q[$];
  logic [FIELD_W-1:0] quotient_q[$];
  int unsigned        error_count;
  int unsigned        cycle_count;
  logic               tail_phase;

  // Restoring division, most significant quotient bit first
  function automatic logic [FIELD_W-1:0] floor_quotient(input logic [FIELD_W-1:0] num_f,
                                                        input logic [FIELD_W-1:0] den_f);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    logic        carry;
    num = 64'(num_f) & OPER_MASK;
    den = 64'(den_f) & OPER_MASK;
    rem = '0;
    quo = '0;
    if (den == '0) return '0;
    for (int b = DW - 1; b >= 0; b--) begin
      carry = rem[63];
      rem   = {rem[62:0], num[b]};
      if (carry || rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    return $urandom();
  endfunction

  function automatic logic [FIELD_W-1:0] edge_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return ALL_ONES;
      3: return TOP_BIT;
      4: return 32'd1 << $urandom_range(0, FIELD_W - 1);
      default: return (32'd1 << $urandom_range(0, FIELD_W - 1)) - 32'd1;
    endcase
  endfunction

  function automatic operands_t random_operands();
    operands_t      op;
    operand_shape_e shape;
    logic [FIELD_W-1:0] k;
    shape = operand_shape_e'($urandom_range(0, SHAPE_COUNT - 1));
    op.dividend = rand_word() >> $urandom_range(0, 8);
    op.divisor  = rand_word();
    case (shape)
      SHAPE_FULL: begin
        op.dividend = rand_word();
      end
      SHAPE_NARROW_DIVISOR: begin
        op.divisor = rand_word() >> $urandom_range(16, FIELD_W - 1);
      end
      SHAPE_ZERO_DIVISOR: begin
        op.dividend = rand_word();
        op.divisor  = '0;
      end
      SHAPE_DIVISOR_ABOVE: begin
        op.divisor  = rand_word() | 32'd1;
        op.dividend = rand_word() % op.divisor;
      end
      SHAPE_EXACT_MULTIPLE: begin
        op.divisor  = (rand_word() >> $urandom_range(8, FIELD_W - 1)) | 32'd1;
        k           = ALL_ONES / op.divisor;
        // A divisor of one allows any multiplier; k + 1 would wrap to zero
        if (k == ALL_ONES)
          op.dividend = op.divisor * rand_word();
        else
          op.dividend = op.divisor * (rand_word() % (k + 32'd1));
      end
      default: begin
        op.dividend = edge_word();
        op.divisor  = edge_word();
      end
    endcase
    return op;
  endfunction

  // Clock, reset and known levels on every input from time zero
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.dividend = '0;
    in_if.divisor = '0;
    out_if.ready  = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: hold the presented item until accepted, idle in short bursts
  int unsigned send_idle;
  always @(posedge clk) begin
    logic      holding;
    operands_t op;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_idle   = 0;
      tail_phase  <= 1'b0;
    end else begin
      holding = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        quotient_q.push_back(floor_quotient(in_if.dividend, in_if.divisor));
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_idle > 0) begin
          send_idle--;
          in_if.valid <= 1'b0;
        end else if (operand_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
          send_idle = $urandom_range(1, 4) - 1;
          in_if.valid <= 1'b0;
        end else begin
          op = operand_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.dividend <= op.dividend;
          in_if.divisor  <= op.divisor;
        end
      end
      tail_phase <= (operand_q.size() < TAIL_ITEMS);
    end
  end

  // Monitor: check each quotient against the oldest expectation
  int unsigned recv_stall;
  always @(posedge clk) begin
    logic [FIELD_W-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (quotient_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected quotient item: actual %h", out_if.quotient);
        end else begin
          want = quotient_q.pop_front();
          if (out_if.quotient !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("quotient mismatch: expected %h actual %h", want, out_if.quotient);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 4) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_unsigned_divider_clz: errors");
      $finish;
    end
  end

  initial begin
    operands_t directed[$];
    error_count = 0;
    cycle_count = 0;

    // Field extremes, zero divisor, divisor above dividend, powers of two
    directed = '{
      '{32'd0,        32'd0},
      '{32'd0,        32'd1},
      '{32'd0,        ALL_ONES},
      '{ALL_ONES,     32'd0},
      '{ALL_ONES,     32'd1},
      '{ALL_ONES,     ALL_ONES},
      '{ALL_ONES,     32'd2},
      '{ALL_ONES,     TOP_BIT},
      '{32'd1,        ALL_ONES},
      '{32'd1,        32'd1},
      '{32'd12345,    32'd0},
      '{32'd7,        32'd8},
      '{32'hFFFF_FFFE, ALL_ONES},
      '{TOP_BIT,      32'd1},
      '{TOP_BIT,      32'd2},
      '{TOP_BIT,      TOP_BIT},
      '{TOP_BIT - 1,  TOP_BIT},
      '{32'd100,      32'd7},
      '{32'hDEAD_BEEF, 32'h0000_BEEF},
      '{32'h5555_5555, 32'hAAAA_AAAA},
      '{32'hAAAA_AAAA, 32'h5555_5555},
      '{32'h0001_0000, 32'h0000_0100},
      '{ALL_ONES,     32'h0000_FFFF}
    };
    foreach (directed[i]) operand_q.push_back(directed[i]);
    repeat (RAND_ITEMS) operand_q.push_back(random_operands());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (operand_q.size() != 0 || in_if.valid) @(posedge clk);
    while (quotient_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0 && quotient_q.size() == 0) begin
      $display("tb_unsigned_divider_clz: clean");
    end else begin
      $display("tb_unsigned_divider_clz: errors");
    end
    $finish;
  end

endmodule

// ===== unsigned_divider_clz.f =====
design/udclz_pkg.sv
design/udclz_if.sv
design/udclz_stage.sv
design/unsigned_divider_clz.sv
design/udclz_checker.sv
tb/tb_unsigned_divider_clz.sv
